>>> hdl/ovle_pkg.sv
// ============================================================================
// ovle_pkg
// Shared types and constants for the ordered value list engine.
// ============================================================================
`default_nettype none

package ovle_pkg;

    // Store geometry
    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;

    // Stream word widths
    localparam int IN_FIELDS_W  = OP_W + VALUE_W + POS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STAT_W + 1 + IDX_W + VALUE_W + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
    localparam logic [OP_W-1:0] OP_UNIQUE   = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
    localparam logic [OP_W-1:0] OP_INDEX_OF = 3'd4;
    localparam logic [OP_W-1:0] OP_POP      = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    // What the cells do with their entries
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } cell_act_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 cmp;
        cell_act_t            act;
        logic [CNT_W-1:0]     where;
        logic [CNT_W-1:0]     count;
        logic [VALUE_W-1:0]   value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/ordered_value_list_engine_unit.sv
// ============================================================================
// ordered_value_list_engine_unit
// Ordered list of values kept in a row of cells, with append, unique append,
// insert, remove, search and pop operations.
// ============================================================================
// Usage:
//   The slave stream carries one command per transfer (op, value, position).
//   The master stream returns exactly one result per command (status, found,
//   match index, popped value, entry count after the operation).
//   Each command passes through four steps: accept, compare in every cell,
//   priority encode of the first match, then execute. The result register
//   loads in the execute step, after the compare and encode steps. The block
//   takes no new command until the previous one has executed, since each
//   command depends on the list contents left by the one before.
//   A finished result sits in the output register while the next command is
//   accepted and compared; only the execute step waits when the receiver
//   stalls and the previous result has not been taken.
//   Reset clears every cell, the entry count and both handshakes; the block
//   is ready to accept a command as soon as reset is released.
// ============================================================================
`default_nettype none

module ordered_value_list_engine_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Command stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: op[2:0], value[34:3], position[41:35], zero pad[47:42]
    input  wire logic [ovle_pkg::IN_TDATA_W-1:0]    s_tdata,
    // Result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: status[1:0], found[2], match_index[8:3], popped_value[40:9],
    //          entry_count_out[47:41]
    output logic      [ovle_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_FIRST = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ovle_pkg::OP_W-1:0]       op_reg, op_next;
    logic [ovle_pkg::VALUE_W-1:0]    value_reg, value_next;
    logic [ovle_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [ovle_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [ovle_pkg::VALUE_W-1:0]    popped_reg, popped_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [ovle_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    ovle_pkg::cell_ctrl_t            ctrl;
    logic [ovle_pkg::VALUE_W-1:0]    cell_vals [ovle_pkg::CAPACITY];
    logic [ovle_pkg::VALUE_W-1:0]    tail_vals [ovle_pkg::CAPACITY];
    logic [ovle_pkg::CAPACITY-1:0]   match_bits;
    logic [ovle_pkg::VALUE_W-1:0]    tail_or;
    logic                            first_hit;
    logic [ovle_pkg::IDX_W-1:0]      first_idx;

    logic                            in_xfer;
    logic                            exec_go;
    logic                            is_full;
    logic [ovle_pkg::STAT_W-1:0]     res_status;
    logic                            res_found;
    logic [ovle_pkg::IDX_W-1:0]      res_index;
    logic [ovle_pkg::VALUE_W-1:0]    res_popped;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign exec_go  = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign is_full  = (count_reg == ovle_pkg::CNT_W'(ovle_pkg::CAPACITY));

    // Row of cells
    for (genvar g = 0; g < ovle_pkg::CAPACITY; g++)
    begin : g_cell
        logic [ovle_pkg::VALUE_W-1:0] left_v;
        logic [ovle_pkg::VALUE_W-1:0] right_v;

        if (g == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = cell_vals[g-1];
        end

        if (g == ovle_pkg::CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_mid_r
            assign right_v = cell_vals[g+1];
        end

        ovle_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .cell_index  (ovle_pkg::IDX_W'(g)),
            .left_value  (left_v),
            .right_value (right_v),
            .entry_value (cell_vals[g]),
            .match       (match_bits[g]),
            .tail_value  (tail_vals[g])
        );
    end

    ovle_first u_first (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (state_reg == S_FIRST),
        .match_bits (match_bits),
        .hit        (first_hit),
        .index      (first_idx)
    );

    // Only the last live cell drives a nonzero tail value.
    always_comb
    begin
        tail_or = '0;
        for (int i = 0; i < ovle_pkg::CAPACITY; i++)
        begin
            tail_or = tail_or | tail_vals[i];
        end
    end

    // Sequencer and command registers
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        popped_next = popped_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = s_tdata[ovle_pkg::OP_W-1:0];
                    value_next = s_tdata[ovle_pkg::OP_W +: ovle_pkg::VALUE_W];
                    pos_next   = s_tdata[ovle_pkg::OP_W + ovle_pkg::VALUE_W +: ovle_pkg::POS_W];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                popped_next = tail_or;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Execute step: status, result fields, cell action and new count
    always_comb
    begin
        ctrl.cmp   = (state_reg == S_CMP);
        ctrl.act   = ovle_pkg::ACT_NONE;
        ctrl.where = count_reg;
        ctrl.count = count_reg;
        ctrl.value = value_reg;
        count_next = count_reg;
        res_status = ovle_pkg::ST_OK;
        res_found  = 1'b0;
        res_index  = '0;
        res_popped = '0;
        case (op_reg)
            ovle_pkg::OP_APPEND:
            begin
                if (is_full)
                begin
                    res_status = ovle_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.act   = ovle_pkg::ACT_INSERT;
                    count_next = count_reg + ovle_pkg::CNT_W'(1);
                end
            end
            ovle_pkg::OP_UNIQUE:
            begin
                if (first_hit)
                begin
                    res_found = 1'b1;
                end
                else if (is_full)
                begin
                    res_status = ovle_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.act   = ovle_pkg::ACT_INSERT;
                    count_next = count_reg + ovle_pkg::CNT_W'(1);
                end
            end
            ovle_pkg::OP_INSERT:
            begin
                if (pos_reg > ovle_pkg::POS_W'(count_reg))
                begin
                    res_status = ovle_pkg::ST_BADPOS;
                end
                else if (is_full)
                begin
                    res_status = ovle_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.act   = ovle_pkg::ACT_INSERT;
                    ctrl.where = ovle_pkg::CNT_W'(pos_reg);
                    count_next = count_reg + ovle_pkg::CNT_W'(1);
                end
            end
            ovle_pkg::OP_REMOVE:
            begin
                if (first_hit)
                begin
                    res_found  = 1'b1;
                    ctrl.act   = ovle_pkg::ACT_REMOVE;
                    ctrl.where = ovle_pkg::CNT_W'(first_idx);
                    count_next = count_reg - ovle_pkg::CNT_W'(1);
                end
            end
            ovle_pkg::OP_INDEX_OF:
            begin
                if (first_hit)
                begin
                    res_found = 1'b1;
                    res_index = first_idx;
                end
            end
            ovle_pkg::OP_POP:
            begin
                if (count_reg == '0)
                begin
                    res_status = ovle_pkg::ST_EMPTY;
                end
                else
                begin
                    res_popped = popped_reg;
                    count_next = count_reg - ovle_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                res_status = ovle_pkg::ST_OK;
            end
        endcase
        if (!exec_go)
        begin
            ctrl.act   = ovle_pkg::ACT_NONE;
            count_next = count_reg;
        end
    end

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (exec_go)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = ovle_pkg::OUT_TDATA_W'({count_next, res_popped, res_index,
                                                    res_found, res_status});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        popped_reg  <= popped_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> hdl/ovle_cell.sv
// ============================================================================
// ovle_cell
// One entry of the list: holds a value, compares it with the search key and
// shifts to or from its neighbors on insert and remove.
// ============================================================================
`default_nettype none

module ovle_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ovle_pkg::cell_ctrl_t           ctrl,
    input  wire logic [ovle_pkg::IDX_W-1:0]     cell_index,
    input  wire logic [ovle_pkg::VALUE_W-1:0]   left_value,
    input  wire logic [ovle_pkg::VALUE_W-1:0]   right_value,
    output logic      [ovle_pkg::VALUE_W-1:0]   entry_value,
    output logic                                match,
    output logic      [ovle_pkg::VALUE_W-1:0]   tail_value
);

    logic [ovle_pkg::VALUE_W-1:0] entry_reg, entry_next;
    logic                         match_reg, match_next;
    logic [ovle_pkg::VALUE_W-1:0] tail_reg, tail_next;
    logic [ovle_pkg::CNT_W-1:0]   idx_ext;
    logic [ovle_pkg::CNT_W-1:0]   idx_inc;

    assign idx_ext = ovle_pkg::CNT_W'(cell_index);
    assign idx_inc = idx_ext + ovle_pkg::CNT_W'(1);

    // Entry update: load, take from the lower neighbor, or take from the upper one.
    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.act)
            ovle_pkg::ACT_INSERT:
            begin
                if (idx_ext == ctrl.where)
                begin
                    entry_next = ctrl.value;
                end
                else if ((idx_ext > ctrl.where) && (idx_ext <= ctrl.count))
                begin
                    entry_next = left_value;
                end
            end
            ovle_pkg::ACT_REMOVE:
            begin
                if ((idx_ext >= ctrl.where) && (idx_inc < ctrl.count))
                begin
                    entry_next = right_value;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Compare against the key and capture the last live entry for a pop.
    always_comb
    begin
        match_next = match_reg;
        tail_next  = tail_reg;
        if (ctrl.cmp)
        begin
            match_next = (entry_reg == ctrl.value) && (idx_ext < ctrl.count);
            tail_next  = (idx_inc == ctrl.count) ? entry_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            match_reg <= 1'b0;
            tail_reg  <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            match_reg <= match_next;
            tail_reg  <= tail_next;
        end
    end

    assign entry_value = entry_reg;
    assign match       = match_reg;
    assign tail_value  = tail_reg;

endmodule

`default_nettype wire

>>> hdl/ovle_first.sv
// ============================================================================
// ovle_first
// Registered priority encoder: finds the lowest cell that reported a match.
// ============================================================================
`default_nettype none

module ovle_first (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            load,
    input  wire logic [ovle_pkg::CAPACITY-1:0]   match_bits,
    output logic                                 hit,
    output logic      [ovle_pkg::IDX_W-1:0]      index
);

    logic [ovle_pkg::CAPACITY-1:0] lowest;
    logic [ovle_pkg::IDX_W-1:0]    enc;
    logic                          hit_reg, hit_next;
    logic [ovle_pkg::IDX_W-1:0]    index_reg, index_next;

    // Isolate the lowest set bit, then encode the one-hot result.
    assign lowest = match_bits & (~match_bits + ovle_pkg::CAPACITY'(1));

    always_comb
    begin
        enc = '0;
        for (int i = 0; i < ovle_pkg::CAPACITY; i++)
        begin
            if (lowest[i])
            begin
                enc = enc | ovle_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        hit_next   = hit_reg;
        index_next = index_reg;
        if (load)
        begin
            hit_next   = |match_bits;
            index_next = enc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            index_reg <= '0;
        end
        else
        begin
            hit_reg   <= hit_next;
            index_reg <= index_next;
        end
    end

    assign hit   = hit_reg;
    assign index = index_reg;

endmodule

`default_nettype wire

>>> hdl/ovle_checker.sv
// ============================================================================
// ovle_checker
// Port-level checks for the ordered value list engine, bound to the top level.
// ============================================================================
`default_nettype none

module ovle_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [ovle_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    logic [ovle_pkg::STAT_W-1:0]  res_status;
    logic [ovle_pkg::CNT_W-1:0]   res_count;
    logic [ovle_pkg::VALUE_W-1:0] res_popped;

    assign res_status = m_tdata[ovle_pkg::STAT_W-1:0];
    assign res_count  = m_tdata[ovle_pkg::OUT_FIELDS_W-1 -: ovle_pkg::CNT_W];
    assign res_popped = m_tdata[ovle_pkg::STAT_W + 1 + ovle_pkg::IDX_W +: ovle_pkg::VALUE_W];

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // The entry count never passes the capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_count <= ovle_pkg::CNT_W'(ovle_pkg::CAPACITY)))
        else $error("entry count beyond capacity");

    // A full status is only given with a full list.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status == ovle_pkg::ST_FULL))
            |-> (res_count == ovle_pkg::CNT_W'(ovle_pkg::CAPACITY)))
        else $error("full status with room left");

    // An empty pop leaves an empty list and returns no value.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status == ovle_pkg::ST_EMPTY))
            |-> ((res_count == '0) && (res_popped == '0)))
        else $error("empty status with entries or a value");

    // A command is worked on alone: no second transfer right after one.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command taken while busy");

endmodule

bind ordered_value_list_engine_unit ovle_checker u_ovle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
